FILE: rtl/core/v3alu_pkg.sv
// shared types, constants and helpers for the vector3 alu
`default_nettype none
package v3alu_pkg;

  localparam int W         = 32;
  localparam int FRAC_BITS = 16;
  localparam int OP_W      = W + 1;
  localparam int PROD_W    = 2 * OP_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SS_W      = 2 * W;
  localparam int ROOT_W    = SS_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int LEN_W     = ROOT_W + 1;
  localparam int DEN_W     = LEN_W + 1;
  localparam int QB        = FRAC_BITS + 1;
  localparam int NUM_W     = W + FRAC_BITS + 2;
  localparam int TOL_W     = W - 1;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [W-1:0] INT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] INT_MIN = {1'b1, {(W-1){1'b0}}};

  // operation codes
  localparam logic [3:0] ACT_ADD    = 4'd0;
  localparam logic [3:0] ACT_SUB    = 4'd1;
  localparam logic [3:0] ACT_SCALE  = 4'd2;
  localparam logic [3:0] ACT_DOT    = 4'd3;
  localparam logic [3:0] ACT_CROSS  = 4'd4;
  localparam logic [3:0] ACT_LEN    = 4'd5;
  localparam logic [3:0] ACT_DIST   = 4'd6;
  localparam logic [3:0] ACT_NORM   = 4'd7;
  localparam logic [3:0] ACT_APPROX = 4'd8;
  localparam logic [3:0] ACT_EQUAL  = 4'd9;

  // register indexes
  localparam logic [1:0] REG_NORM_TOL  = 2'd0;
  localparam logic [1:0] REG_EQUAL_TOL = 2'd1;

  typedef struct packed {
    logic [W-1:0] val;
    logic         ovf;
  } sat_t;

  // word travelling alongside the arithmetic
  typedef struct packed {
    logic [3:0]          action;
    logic [2:0]          sgn;
    logic [2:0][W-1:0]   mag;
    logic                huge;
    logic                tol_neg;
    logic [2:0][W-1:0]   vec;
    logic [W-1:0]        scal;
    logic                match;
    logic                ovf;
    logic                nz;
  } meta_t;

  typedef struct packed {
    logic [SS_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    nb;
    logic [QB-1:0]    q;
  } div_lane_t;

  typedef struct packed {
    logic [DEN_W-1:0]     den;
    div_lane_t [2:0]      lane;
  } div_t;

  // clamp a wide signed value to a word
  function automatic sat_t sat_word(input logic signed [SUM_W-1:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[W-1:0];
    if (v > SUM_W'(INT_MAX)) begin
      r.val = INT_MAX;
      r.ovf = 1'b1;
    end else if (v < SUM_W'(INT_MIN)) begin
      r.val = INT_MIN;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/v3alu_front.sv
// operand selection, shared multipliers and rounding stages
`default_nettype none
module v3alu_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [3:0]                    action,
  input  wire logic [2:0][v3alu_pkg::W-1:0]  a,
  input  wire logic [2:0][v3alu_pkg::W-1:0]  b,
  input  wire logic [v3alu_pkg::W-1:0]       s,
  input  wire logic [v3alu_pkg::TOL_W-1:0]   eq_tol,
  output logic                               out_valid,
  output v3alu_pkg::meta_t                   out_meta,
  output v3alu_pkg::sq_t                     out_sq
);
  import v3alu_pkg::*;

  logic signed [OP_W-1:0]   ma_next [6];
  logic signed [OP_W-1:0]   mb_next [6];
  logic signed [OP_W-1:0]   ma [6];
  logic signed [OP_W-1:0]   mb [6];
  logic signed [PROD_W-1:0] prod [6];
  logic signed [OP_W-1:0]   av [3];
  logic signed [OP_W-1:0]   bv [3];
  logic signed [OP_W-1:0]   dv [3];
  logic signed [OP_W-1:0]   sv;
  logic [OP_W-1:0]          dmag [3];
  logic signed [OP_W-1:0]   tolv;
  meta_t                    m1_next, m1, m2, m3_next;
  logic                     v1, v2;
  logic signed [SUM_W-1:0]  px [6];
  logic signed [SUM_W-1:0]  acc [3];
  logic signed [SUM_W-1:0]  dsum;
  logic [SS_W-1:0]          ss;
  sat_t                     st [3];
  sat_t                     sd;

  // operand selection per operation
  always_comb begin
    m1_next = '0;
    m1_next.action = action;
    sv = {s[W-1], s};
    for (int i = 0; i < 3; i++) begin
      av[i] = {a[i][W-1], a[i]};
      bv[i] = {b[i][W-1], b[i]};
      dv[i] = bv[i] - av[i];
      dmag[i] = dv[i][OP_W-1] ? OP_W'(-dv[i]) : OP_W'(dv[i]);
      m1_next.sgn[i] = a[i][W-1];
      m1_next.mag[i] = a[i][W-1] ? W'(-av[i]) : a[i];
    end
    m1_next.huge = (dmag[0] > (OP_W'(1) << (W - 1))) || (dmag[1] > (OP_W'(1) << (W - 1)))
                   || (dmag[2] > (OP_W'(1) << (W - 1)));
    m1_next.tol_neg = (action == ACT_APPROX) && s[W-1];
    tolv = (action == ACT_APPROX) ? {2'b00, s[TOL_W-1:0]} : {2'b00, eq_tol};
    for (int k = 0; k < 6; k++) begin
      ma_next[k] = '0;
      mb_next[k] = '0;
    end
    unique case (action)
      ACT_ADD, ACT_SUB: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = (action == ACT_ADD) ? av[i] + bv[i] : av[i] - bv[i];
          mb_next[i] = OP_W'(1);
        end
      end
      ACT_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = av[i];
          mb_next[i] = sv;
        end
      end
      ACT_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = av[i];
          mb_next[i] = bv[i];
        end
      end
      ACT_CROSS: begin
        ma_next[0] = av[1]; mb_next[0] = bv[2];
        ma_next[1] = av[2]; mb_next[1] = bv[1];
        ma_next[2] = av[2]; mb_next[2] = bv[0];
        ma_next[3] = av[0]; mb_next[3] = bv[2];
        ma_next[4] = av[0]; mb_next[4] = bv[1];
        ma_next[5] = av[1]; mb_next[5] = bv[0];
      end
      ACT_LEN, ACT_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = av[i];
          mb_next[i] = av[i];
        end
      end
      ACT_DIST, ACT_APPROX, ACT_EQUAL: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = dv[i];
          mb_next[i] = dv[i];
        end
        ma_next[3] = tolv;
        mb_next[3] = tolv;
      end
      default: begin
      end
    endcase
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        ma[k] <= ma_next[k];
        mb[k] <= mb_next[k];
        prod[k] <= ma[k] * mb[k];
      end
      m1 <= m1_next;
      m2 <= m1;
      out_meta <= m3_next;
      out_sq.rad <= ss;
      out_sq.rem <= '0;
      out_sq.root <= '0;
    end
  end

  // sums, rounding and saturation
  always_comb begin
    m3_next = m2;
    for (int k = 0; k < 6; k++) begin
      px[k] = SUM_W'(prod[k]);
    end
    acc[0] = (px[0] - px[1] + ROUND_HALF) >>> FRAC_BITS;
    acc[1] = (px[2] - px[3] + ROUND_HALF) >>> FRAC_BITS;
    acc[2] = (px[4] - px[5] + ROUND_HALF) >>> FRAC_BITS;
    dsum = (px[0] + px[1] + px[2] + ROUND_HALF) >>> FRAC_BITS;
    ss = SS_W'(px[0] + px[1] + px[2]);
    for (int i = 0; i < 3; i++) begin
      st[i] = '0;
    end
    sd = sat_word(dsum);
    unique case (m2.action)
      ACT_ADD, ACT_SUB: for (int i = 0; i < 3; i++) st[i] = sat_word(px[i]);
      ACT_SCALE: for (int i = 0; i < 3; i++) st[i] = sat_word((px[i] + ROUND_HALF) >>> FRAC_BITS);
      ACT_CROSS: for (int i = 0; i < 3; i++) st[i] = sat_word(acc[i]);
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      m3_next.vec[i] = st[i].val;
    end
    m3_next.ovf = st[0].ovf | st[1].ovf | st[2].ovf;
    m3_next.scal = '0;
    if (m2.action == ACT_DOT) begin
      m3_next.scal = sd.val;
      m3_next.ovf = sd.ovf;
    end
    m3_next.match = ((m2.action == ACT_APPROX) || (m2.action == ACT_EQUAL)) && !m2.huge
                    && !m2.tol_neg && (ss <= SS_W'(prod[3]));
  end

endmodule
`default_nettype wire

FILE: rtl/core/v3alu_sqrt_cell.sv
// one digit step of the square root chain
`default_nettype none
module v3alu_sqrt_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  v3alu_pkg::meta_t       in_meta,
  input  v3alu_pkg::sq_t         in_sq,
  output logic                   out_valid,
  output v3alu_pkg::meta_t       out_meta,
  output v3alu_pkg::sq_t         out_sq
);
  import v3alu_pkg::*;

  logic [REM_W+1:0] part;
  logic [REM_W+1:0] trial;
  logic             ge;
  sq_t              sq_next;

  // bring in two radicand bits and try the next root bit
  always_comb begin
    part  = {in_sq.rem, in_sq.rad[SS_W-1 -: 2]};
    trial = (REM_W + 2)'({in_sq.root, 2'b01});
    ge    = part >= trial;
    sq_next.rad  = in_sq.rad << 2;
    sq_next.rem  = ge ? REM_W'(part - trial) : REM_W'(part);
    sq_next.root = {in_sq.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_meta <= in_meta;
      out_sq   <= sq_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/v3alu_div_cell.sv
// one quotient bit of the three-lane normalize divider
`default_nettype none
module v3alu_div_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  v3alu_pkg::meta_t       in_meta,
  input  v3alu_pkg::div_t        in_div,
  output logic                   out_valid,
  output v3alu_pkg::meta_t       out_meta,
  output v3alu_pkg::div_t        out_div
);
  import v3alu_pkg::*;

  logic [DEN_W:0] part [3];
  logic           ge [3];
  div_t           div_next;

  // restoring step in each lane
  always_comb begin
    div_next.den = in_div.den;
    for (int i = 0; i < 3; i++) begin
      part[i] = {in_div.lane[i].rem, in_div.lane[i].nb[QB-1]};
      ge[i]   = part[i] >= {1'b0, in_div.den};
      div_next.lane[i].rem = ge[i] ? DEN_W'(part[i] - {1'b0, in_div.den})
                                   : DEN_W'(part[i]);
      div_next.lane[i].nb  = in_div.lane[i].nb << 1;
      div_next.lane[i].q   = {in_div.lane[i].q[QB-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_meta <= in_meta;
      out_div  <= div_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/vector3_alu.sv
// vector3 alu top level: front stages, square root chain, divider chain, output word
//
// Input words come on in_valid/in_ready with the operation code, two vectors and
// a scalar; result words leave on out_valid/out_ready. Every input word gives
// exactly one result word, in order.
// The chain has three front stages (operand select, multiply, sum and round),
// 32 square root cells, one length stage, 17 divider cells and the output
// register. Every operation walks the whole chain so order is kept. Throughput
// is one word per cycle while in_ready is high. The whole chain moves together; it
// keeps moving while the output register waits, as long as the last cell holds no
// word, so in_ready drops only when a finished word meets a stalled receiver.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; writes are meant for when no word is in flight.
// Reset (rst, synchronous) empties the chain and the output register and loads
// norm_tolerance = 7 and equal_tolerance = 0.
`default_nettype none
module vector3_alu (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [3:0]           action,
  input  wire logic signed [31:0]   a_x,
  input  wire logic signed [31:0]   a_y,
  input  wire logic signed [31:0]   a_z,
  input  wire logic signed [31:0]   b_x,
  input  wire logic signed [31:0]   b_y,
  input  wire logic signed [31:0]   b_z,
  input  wire logic signed [31:0]   scalar_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        r_x,
  output logic signed [31:0]        r_y,
  output logic signed [31:0]        r_z,
  output logic signed [31:0]        scalar_out,
  output logic                      match_flag,
  output logic                      overflow,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [30:0]          cfg_data
);
  import v3alu_pkg::*;

  logic [TOL_W-1:0]  norm_tol;
  logic [TOL_W-1:0]  equal_tol;
  logic              en;

  logic              sq_v [SQ_STEPS+1];
  meta_t             sq_m [SQ_STEPS+1];
  sq_t               sq_d [SQ_STEPS+1];

  logic              dv_v [QB+1];
  meta_t             dv_m [QB+1];
  div_t              dv_d [QB+1];

  logic [LEN_W-1:0]  len;
  logic [NUM_W-1:0]  num [3];
  meta_t             lm_next;
  div_t              ld_next;
  sat_t              len_sat;
  logic [W-1:0]      qv [3];

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_tol  <= TOL_W'(7);
      equal_tol <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NORM_TOL) begin
        norm_tol <= cfg_data;
      end else if (cfg_index == REG_EQUAL_TOL) begin
        equal_tol <= cfg_data;
      end
    end
  end

  // chain advances unless a finished word meets a stalled output
  assign en       = !out_valid || out_ready || !dv_v[QB];
  assign in_ready = en;

  v3alu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .action    (action),
    .a         ({a_z, a_y, a_x}),
    .b         ({b_z, b_y, b_x}),
    .s         (scalar_in),
    .eq_tol    (equal_tol),
    .out_valid (sq_v[0]),
    .out_meta  (sq_m[0]),
    .out_sq    (sq_d[0])
  );

  // square root chain
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    v3alu_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_v[k]),
      .in_meta   (sq_m[k]),
      .in_sq     (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_meta  (sq_m[k+1]),
      .out_sq    (sq_d[k+1])
    );
  end

  // rounded length, length and distance results, divider setup
  always_comb begin
    len = {1'b0, sq_d[SQ_STEPS].root}
          + LEN_W'(sq_d[SQ_STEPS].rem > REM_W'(sq_d[SQ_STEPS].root));
    len_sat.ovf = len > LEN_W'(INT_MAX);
    len_sat.val = len_sat.ovf ? INT_MAX : len[W-1:0];
    lm_next = sq_m[SQ_STEPS];
    lm_next.nz = len > LEN_W'(norm_tol);
    if (sq_m[SQ_STEPS].action == ACT_LEN) begin
      lm_next.scal = len_sat.val;
      lm_next.ovf  = len_sat.ovf;
    end else if (sq_m[SQ_STEPS].action == ACT_DIST) begin
      lm_next.scal = sq_m[SQ_STEPS].huge ? INT_MAX : len_sat.val;
      lm_next.ovf  = sq_m[SQ_STEPS].huge | len_sat.ovf;
    end
    ld_next.den = {len, 1'b0};
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUM_W'(sq_m[SQ_STEPS].mag[i]) << (FRAC_BITS + 1)) + NUM_W'(len);
      ld_next.lane[i].rem = DEN_W'(num[i][NUM_W-1:QB]);
      ld_next.lane[i].nb  = num[i][QB-1:0];
      ld_next.lane[i].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ_STEPS];
    end
    if (en) begin
      dv_m[0] <= lm_next;
      dv_d[0] <= ld_next;
    end
  end

  // divider chain
  for (genvar k = 0; k < QB; k++) begin : g_div
    v3alu_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_v[k]),
      .in_meta   (dv_m[k]),
      .in_div    (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_meta  (dv_m[k+1]),
      .out_div   (dv_d[k+1])
    );
  end

  // signed normalize components; other operations pass their vector result
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = W'(dv_d[QB].lane[i].q);
      if (dv_m[QB].action != ACT_NORM) begin
        qv[i] = dv_m[QB].vec[i];
      end else if (!dv_m[QB].nz) begin
        qv[i] = '0;
      end else if (dv_m[QB].sgn[i]) begin
        qv[i] = -W'(dv_d[QB].lane[i].q);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && dv_v[QB]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (en && dv_v[QB]) begin
      r_x        <= qv[0];
      r_y        <= qv[1];
      r_z        <= qv[2];
      scalar_out <= dv_m[QB].scal;
      match_flag <= dv_m[QB].match;
      overflow   <= dv_m[QB].ovf;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_match_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_flag |-> !overflow && scalar_out == 0)
    else $error("match word carries other results");
  a_match_no_vec: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_flag |-> r_x == 0 && r_y == 0 && r_z == 0)
    else $error("match word carries a vector");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output valid after reset");

endmodule
`default_nettype wire
